// ===== rtl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared widths, constants and types of the smallest-prime-factor factorizer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int VALUE_W        = 16;
    localparam int EXP_W          = 5;
    localparam int TABLE_SIZE_DEF = 65536;
    localparam int FIRST_PRIME    = 2;
    localparam int QUEUE_DEPTH    = 2;

    // Classified input item, front to back
    typedef struct packed {
        logic               empty;
        logic [VALUE_W-1:0] value;
    } t_item;

    // Table write port, sieve to table memories
    typedef struct packed {
        logic               we;
        logic [VALUE_W-1:0] addr;
        logic [VALUE_W-1:0] spf;
        logic [VALUE_W-1:0] cof;
    } t_tbl_wr;

    typedef enum logic [2:0] {
        SV_CLEAR,
        SV_RD_V,
        SV_CHK_V,
        SV_RD_P,
        SV_MUL,
        SV_WR,
        SV_DONE
    } t_sieve_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMPTY,
        BK_STEP,
        BK_FINAL
    } t_back_state;

endpackage

// ===== rtl/spf_ram.sv =====
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = spf_pkg::VALUE_W,
    parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spf_sieve.sv =====
// ----------------------------------------------------------------------------
// spf_sieve
// Clears the factor tables after reset, then fills them with a linear sieve.
// ----------------------------------------------------------------------------
module spf_sieve #(
    parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [$clog2(DEPTH)-1:0] i_spf_rdata,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    output spf_pkg::t_tbl_wr         o_tbl_wr,
    output logic                     o_done
);

    localparam int AW       = $clog2(DEPTH);
    // Only primes below sqrt(DEPTH) are ever multiplied; the list covers all of them
    localparam int ROOT     = 2 ** ((AW + 1) / 2);
    localparam int PL_DEPTH = ROOT / 2 + 2;
    localparam int PLW      = $clog2(PL_DEPTH);
    localparam int CW       = $clog2(PL_DEPTH + 1);
    localparam int PW       = 2 * AW;
    localparam logic [AW-1:0] V_LAST = AW'(DEPTH - 1);

    spf_pkg::t_sieve_state r_state, n_state;
    logic [AW-1:0] r_v, n_v;
    logic [AW-1:0] r_spf_v, n_spf_v;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_p, n_p;
    logic [PW-1:0] r_prod, n_prod;
    logic          w_next;
    logic          w_pl_we;
    logic [AW-1:0] w_pl_rdata;

    spf_ram #(
        .WIDTH (AW),
        .DEPTH (PL_DEPTH)
    ) u_plist (
        .i_clk   (i_clk),
        .i_we    (w_pl_we),
        .i_waddr (r_cnt[PLW-1:0]),
        .i_wdata (r_v),
        .i_raddr (r_k[PLW-1:0]),
        .o_rdata (w_pl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spf_pkg::SV_CLEAR;
            r_v     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
            r_cnt   <= n_cnt;
        end
        r_spf_v <= n_spf_v;
        r_k     <= n_k;
        r_p     <= n_p;
        r_prod  <= n_prod;
    end

    always_comb begin
        n_state   = r_state;
        n_v       = r_v;
        n_spf_v   = r_spf_v;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_p       = r_p;
        n_prod    = r_prod;
        w_next    = 1'b0;
        w_pl_we   = 1'b0;
        o_tbl_wr  = '0;
        o_rd_addr = r_v;
        unique case (r_state)
            spf_pkg::SV_CLEAR: begin
                o_tbl_wr.we   = 1'b1;
                o_tbl_wr.addr = spf_pkg::VALUE_W'(r_v);
                if (r_v == V_LAST) begin
                    n_v     = AW'(spf_pkg::FIRST_PRIME);
                    n_state = spf_pkg::SV_RD_V;
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            spf_pkg::SV_RD_V: begin
                n_state = spf_pkg::SV_CHK_V;
            end
            spf_pkg::SV_CHK_V: begin
                n_k     = '0;
                n_state = spf_pkg::SV_RD_P;
                if (i_spf_rdata == '0) begin
                    // untouched entry: v is prime
                    n_spf_v       = r_v;
                    o_tbl_wr.we   = 1'b1;
                    o_tbl_wr.addr = spf_pkg::VALUE_W'(r_v);
                    o_tbl_wr.spf  = spf_pkg::VALUE_W'(r_v);
                    if (r_cnt < CW'(PL_DEPTH)) begin
                        w_pl_we = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end else begin
                    n_spf_v = i_spf_rdata;
                end
            end
            spf_pkg::SV_RD_P: begin
                if (r_k < r_cnt) begin
                    n_state = spf_pkg::SV_MUL;
                end else begin
                    w_next = 1'b1;
                end
            end
            spf_pkg::SV_MUL: begin
                n_p     = w_pl_rdata;
                n_prod  = PW'(w_pl_rdata) * PW'(r_v);
                n_state = spf_pkg::SV_WR;
            end
            spf_pkg::SV_WR: begin
                if (r_prod < PW'(DEPTH) && r_p <= r_spf_v) begin
                    o_tbl_wr.we   = 1'b1;
                    o_tbl_wr.addr = spf_pkg::VALUE_W'(r_prod[AW-1:0]);
                    o_tbl_wr.spf  = spf_pkg::VALUE_W'(r_p);
                    o_tbl_wr.cof  = spf_pkg::VALUE_W'(r_v);
                    n_k           = r_k + 1'b1;
                    n_state       = spf_pkg::SV_RD_P;
                end else begin
                    w_next = 1'b1;
                end
            end
            spf_pkg::SV_DONE: begin
            end
            default: begin
                n_state = spf_pkg::SV_CLEAR;
            end
        endcase
        // advance to the next value, or finish the build
        if (w_next) begin
            if (r_v == V_LAST) begin
                n_state = spf_pkg::SV_DONE;
            end else begin
                n_v     = r_v + 1'b1;
                n_state = spf_pkg::SV_RD_V;
            end
        end
    end

    assign o_done = (r_state == spf_pkg::SV_DONE);

endmodule

// ===== rtl/spf_front.sv =====
// ----------------------------------------------------------------------------
// spf_front
// Accepts input beats, flags values that give an empty result, and queues
// them for the back end.
// ----------------------------------------------------------------------------
module spf_front #(
    parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [spf_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_table_ready,
    output spf_pkg::t_item              o_item,
    output logic                        o_item_valid,
    input  logic                        i_item_pop
);

    localparam int QD    = spf_pkg::QUEUE_DEPTH;
    localparam int QW    = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW   = $clog2(QD + 1);
    localparam int CMP_W = spf_pkg::VALUE_W + 1;

    spf_pkg::t_item r_q [QD];
    logic [QW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;
    spf_pkg::t_item w_item;
    logic           w_push, w_pop;

    always_comb begin
        w_item.value = i_value;
        w_item.empty = (i_value < spf_pkg::VALUE_W'(spf_pkg::FIRST_PRIME))
                    || (CMP_W'(i_value) >= CMP_W'(DEPTH));
    end

    assign o_ready      = i_table_ready && (r_count != QCW'(QD));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ===== rtl/spf_back.sv =====
// ----------------------------------------------------------------------------
// spf_back
// Walks the cofactor chain of one queued value, merges equal primes into
// exponents and drives the registered result channel.
// ----------------------------------------------------------------------------
module spf_back #(
    parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spf_pkg::t_item              i_item,
    input  logic                        i_item_valid,
    output logic                        o_item_pop,
    output logic [$clog2(DEPTH)-1:0]    o_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]    i_spf,
    input  logic [$clog2(DEPTH)-1:0]    i_cof,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [spf_pkg::VALUE_W-1:0] o_prime,
    output logic [spf_pkg::EXP_W-1:0]   o_exponent,
    output logic                        o_value_is_prime,
    output logic                        o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = spf_pkg::EXP_W;

    spf_pkg::t_back_state r_state, n_state;
    logic [AW-1:0] r_x, n_x;
    logic [AW-1:0] r_prime, n_prime;
    logic [EW-1:0] r_exp, n_exp;
    logic          r_have, n_have;
    logic          r_first, n_first;
    logic          r_is_prime, n_is_prime;

    logic                        r_out_valid;
    logic [spf_pkg::VALUE_W-1:0] r_out_prime;
    logic [EW-1:0]               r_out_exp;
    logic                        r_out_is_prime;
    logic                        r_out_last;

    logic                        w_slot;
    logic                        w_adv;
    logic                        w_step_is_prime;
    logic                        w_load;
    logic [spf_pkg::VALUE_W-1:0] w_ld_prime;
    logic [EW-1:0]               w_ld_exp;
    logic                        w_ld_is_prime;
    logic                        w_ld_last;

    assign w_slot          = !r_out_valid || i_ready;
    assign w_step_is_prime = r_first ? (i_spf == r_x) : r_is_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spf_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_x        <= n_x;
        r_prime    <= n_prime;
        r_exp      <= n_exp;
        r_have     <= n_have;
        r_first    <= n_first;
        r_is_prime <= n_is_prime;
        if (w_load) begin
            r_out_prime    <= w_ld_prime;
            r_out_exp      <= w_ld_exp;
            r_out_is_prime <= w_ld_is_prime;
            r_out_last     <= w_ld_last;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_prime       = r_prime;
        n_exp         = r_exp;
        n_have        = r_have;
        n_first       = r_first;
        n_is_prime    = r_is_prime;
        o_item_pop    = 1'b0;
        w_adv         = 1'b0;
        w_load        = 1'b0;
        w_ld_prime    = '0;
        w_ld_exp      = '0;
        w_ld_is_prime = r_is_prime;
        w_ld_last     = 1'b0;
        unique case (r_state)
            spf_pkg::BK_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (i_item.empty) begin
                        n_state = spf_pkg::BK_EMPTY;
                    end else begin
                        n_x     = i_item.value[AW-1:0];
                        n_have  = 1'b0;
                        n_first = 1'b1;
                        n_state = spf_pkg::BK_STEP;
                    end
                end
            end
            spf_pkg::BK_EMPTY: begin
                if (w_slot) begin
                    w_load        = 1'b1;
                    w_ld_is_prime = 1'b0;
                    w_ld_last     = 1'b1;
                    n_state       = spf_pkg::BK_IDLE;
                end
            end
            spf_pkg::BK_STEP: begin
                if (i_spf == '0) begin
                    // no factor recorded: stop the walk
                    n_first    = 1'b0;
                    n_is_prime = w_step_is_prime;
                    n_state    = spf_pkg::BK_FINAL;
                end else if (r_have && i_spf != r_prime) begin
                    // new prime: send the finished one, hold if the slot is busy
                    if (w_slot) begin
                        w_load        = 1'b1;
                        w_ld_prime    = spf_pkg::VALUE_W'(r_prime);
                        w_ld_exp      = r_exp;
                        w_ld_is_prime = w_step_is_prime;
                        n_prime       = i_spf;
                        n_exp         = EW'(1);
                        w_adv         = 1'b1;
                    end
                end else begin
                    if (r_have) begin
                        n_exp = r_exp + 1'b1;
                    end else begin
                        n_prime = i_spf;
                        n_exp   = EW'(1);
                        n_have  = 1'b1;
                    end
                    w_adv = 1'b1;
                end
            end
            spf_pkg::BK_FINAL: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_ld_last = 1'b1;
                    if (r_have) begin
                        w_ld_prime = spf_pkg::VALUE_W'(r_prime);
                        w_ld_exp   = r_exp;
                    end
                    n_state = spf_pkg::BK_IDLE;
                end
            end
        endcase
        // follow the cofactor; a cofactor of one or zero ends the chain
        if (w_adv) begin
            n_first    = 1'b0;
            n_is_prime = w_step_is_prime;
            if (i_cof > AW'(1)) begin
                n_x = i_cof;
            end else begin
                n_state = spf_pkg::BK_FINAL;
            end
        end
    end

    // read at n_x so that, once the build is done, the registered read data holds the entry of r_x
    assign o_rd_addr        = n_x;
    assign o_valid          = r_out_valid;
    assign o_prime          = r_out_prime;
    assign o_exponent       = r_out_exp;
    assign o_value_is_prime = r_out_is_prime;
    assign o_last           = r_out_last;

endmodule

// ===== rtl/sieve_prime_factorizer_top.sv =====
// ----------------------------------------------------------------------------
// sieve_prime_factorizer_top
// Factorizes 16-bit values into distinct primes with exponents, using
// smallest-factor and cofactor tables built by a linear sieve after reset.
// ----------------------------------------------------------------------------
// Input channel: one value per beat. Output channel: one beat per distinct
// prime in ascending order with its exponent; o_value_is_prime repeats on
// every beat of a value and o_last marks its final beat. Values below two or
// outside the table give one beat with prime 0, exponent 0 and o_last set.
// Reset: the tables are cleared, one entry a cycle over all TABLE_SIZE
// entries (capped at 65536), then filled by the sieve. o_ready stays low
// for the whole build.
// Back end: it takes a value from the queue, steps once per prime factor
// counted with multiplicity along the cofactor chain through the single
// table read port, then sends the final beat; it takes no new value until
// that beat is loaded.
// A two-entry queue lets the input side accept while results wait; when the
// receiver holds i_ready low the output register holds its beat and the walk
// pauses once it has a beat to send, then the queue fills and o_ready drops.
// ----------------------------------------------------------------------------
module sieve_prime_factorizer_top #(
    parameter int TABLE_SIZE = spf_pkg::TABLE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [spf_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [spf_pkg::VALUE_W-1:0] o_prime,
    output logic [spf_pkg::EXP_W-1:0]   o_exponent,
    output logic                        o_value_is_prime,
    output logic                        o_last
);

    // entries at or above 2**VALUE_W are never looked up
    localparam int DEPTH = (TABLE_SIZE < 2 ** spf_pkg::VALUE_W) ? TABLE_SIZE
                                                                : 2 ** spf_pkg::VALUE_W;
    localparam int AW    = $clog2(DEPTH);

    spf_pkg::t_tbl_wr w_tbl_wr;
    spf_pkg::t_item   w_item;
    logic             w_item_valid;
    logic             w_item_pop;
    logic             w_done;
    logic [AW-1:0]    w_sieve_addr;
    logic [AW-1:0]    w_back_addr;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_spf;
    logic [AW-1:0]    w_cof;

    assign w_rd_addr = w_done ? w_back_addr : w_sieve_addr;

    spf_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_spf_tbl (
        .i_clk   (i_clk),
        .i_we    (w_tbl_wr.we),
        .i_waddr (w_tbl_wr.addr[AW-1:0]),
        .i_wdata (w_tbl_wr.spf[AW-1:0]),
        .i_raddr (w_rd_addr),
        .o_rdata (w_spf)
    );

    spf_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_cof_tbl (
        .i_clk   (i_clk),
        .i_we    (w_tbl_wr.we),
        .i_waddr (w_tbl_wr.addr[AW-1:0]),
        .i_wdata (w_tbl_wr.cof[AW-1:0]),
        .i_raddr (w_rd_addr),
        .o_rdata (w_cof)
    );

    spf_sieve #(
        .DEPTH (DEPTH)
    ) u_sieve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_spf_rdata (w_spf),
        .o_rd_addr   (w_sieve_addr),
        .o_tbl_wr    (w_tbl_wr),
        .o_done      (w_done)
    );

    spf_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_table_ready (w_done),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_pop    (w_item_pop)
    );

    spf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (w_item),
        .i_item_valid     (w_item_valid),
        .o_item_pop       (w_item_pop),
        .o_rd_addr        (w_back_addr),
        .i_spf            (w_spf),
        .i_cof            (w_cof),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_prime          (o_prime),
        .o_exponent       (o_exponent),
        .o_value_is_prime (o_value_is_prime),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/spf_checker.sv =====
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks of the factorizer, bound to the top level.
// ----------------------------------------------------------------------------
module spf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [spf_pkg::VALUE_W-1:0] o_prime,
    input logic [spf_pkg::EXP_W-1:0]   o_exponent,
    input logic                        o_value_is_prime,
    input logic                        o_last
);

    // reset restarts the table build: no beats either way right after
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready or valid high right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_prime)
                                && $stable(o_exponent) && $stable(o_last))
        else $error("stalled result beat changed");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_prime == '0 || o_exponent == '0)
            |-> o_prime == '0 && o_exponent == '0 && o_last)
        else $error("empty result is not a lone final beat");

    a_prime_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_value_is_prime |-> o_last && o_exponent == 1 && o_prime != '0)
        else $error("prime value not reported as single factor");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> !o_valid || o_prime > $past(o_prime))
        else $error("primes of one value not ascending");

endmodule

bind sieve_prime_factorizer_top spf_checker u_spf_checker (.*);
